### design/tsts_pkg.sv
// Shared types, constants and microcode ROM for the tolerant sorted table search.
`default_nettype none
package tsts_pkg;

	localparam int DEPTH_DEF  = 1024;
	localparam int VALUE_W    = 32;
	localparam int POS_W      = 10;
	localparam int TOL_W      = 31;
	localparam int COUNT_W    = 11;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_W      = 31;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		REG_ENTRIES   = 1'b0,
		REG_TOLERANCE = 1'b1
	} reg_idx_t;

	typedef logic [2:0] step_t;

	localparam step_t ST_IDLE     = 3'd0;
	localparam step_t ST_DISPATCH = 3'd1;
	localparam step_t ST_INIT     = 3'd2;
	localparam step_t ST_PROBE    = 3'd3;
	localparam step_t ST_NARROW   = 3'd4;
	localparam step_t ST_FINAL    = 3'd5;
	localparam step_t ST_CHECK    = 3'd6;
	localparam step_t ST_RESULT   = 3'd7;

	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_NO_REQ    = 3'd2,
		C_IS_WRITE  = 3'd3,
		C_EMPTY     = 3'd4,
		C_CONVERGED = 3'd5,
		C_OUT_BUSY  = 3'd6
	} cond_t;

	typedef struct packed {
		logic take;
		logic wr;
		logic clr;
		logic init;
		logic rd_mid;
		logic rd_lo;
		logic upd;
		logic chk;
		logic emit;
	} ctl_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		ctl_t  ctl;
	} ucw_t;

	typedef struct packed {
		logic empty;
		logic converged;
		logic is_write;
	} dp_stat_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_index;
	} res_t;

	localparam ctl_t CTL_NONE = '0;

	function automatic ucw_t ucode(input step_t step);
		ucw_t w;
		begin
			w.cond   = C_NEXT;
			w.target = ST_IDLE;
			w.ctl    = CTL_NONE;
			case (step)
				ST_IDLE: begin
					w.ctl.take = 1'b1;
					w.cond     = C_NO_REQ;
					w.target   = ST_IDLE;
				end
				ST_DISPATCH: begin
					w.ctl.wr  = 1'b1;
					w.ctl.clr = 1'b1;
					w.cond    = C_IS_WRITE;
					w.target  = ST_RESULT;
				end
				ST_INIT: begin
					w.ctl.init = 1'b1;
					w.cond     = C_EMPTY;
					w.target   = ST_RESULT;
				end
				ST_PROBE: begin
					w.ctl.rd_mid = 1'b1;
					w.cond       = C_CONVERGED;
					w.target     = ST_FINAL;
				end
				ST_NARROW: begin
					w.ctl.upd = 1'b1;
					w.cond    = C_ALWAYS;
					w.target  = ST_PROBE;
				end
				ST_FINAL: begin
					w.ctl.rd_lo = 1'b1;
				end
				ST_CHECK: begin
					w.ctl.chk = 1'b1;
				end
				ST_RESULT: begin
					// falls through to idle by wrap of the step counter
					w.ctl.emit = 1'b1;
					w.cond     = C_OUT_BUSY;
					w.target   = ST_RESULT;
				end
				default: begin
					w.cond   = C_ALWAYS;
					w.target = ST_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage
`default_nettype wire

### design/tsts_useq.sv
// Microcode sequencer: step counter, control ROM and jump condition select.
`default_nettype none
module tsts_useq
	import tsts_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      req,
	input  wire      out_busy,
	input  dp_stat_t stat,
	output ctl_t     ctl
);

	step_t step_q;
	ucw_t  word;
	logic  jump;

	assign word = ucode(step_q);
	assign ctl  = word.ctl;

	always_comb begin
		case (word.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_REQ:    jump = !req;
			C_IS_WRITE:  jump = stat.is_write;
			C_EMPTY:     jump = stat.empty;
			C_CONVERGED: jump = stat.converged;
			C_OUT_BUSY:  jump = out_busy;
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (jump) begin
			step_q <= word.target;
		end else begin
			step_q <= step_q + 3'd1;
		end
	end

	a_result_wraps_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_RESULT && !out_busy) |=> step_q == ST_IDLE)
		else $error("result step did not return to idle");

	a_write_skips_search: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_DISPATCH && stat.is_write) |=> step_q == ST_RESULT)
		else $error("write request entered the search");

	a_narrow_back_to_probe: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> step_q == ST_PROBE)
		else $error("narrow step did not return to probe");

endmodule
`default_nettype wire

### design/tsts_dp.sv
// Search datapath: table memory, bounds registers, compare and match check.
`default_nettype none
module tsts_dp
	import tsts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF
)(
	input  wire                clk,
	input  wire                arst_n,
	input  ctl_t               ctl,
	input  wire                load,
	input  op_t                op,
	input  wire [POS_W-1:0]    position,
	input  wire [VALUE_W-1:0]  value,
	input  wire [COUNT_W-1:0]  entries_in_use,
	input  wire [TOL_W-1:0]    tolerance,
	output dp_stat_t           stat,
	output res_t               res
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [VALUE_W-1:0] mem [TABLE_DEPTH];

	op_t                op_q;
	logic [POS_W-1:0]   pos_q;
	logic [VALUE_W-1:0] key_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [IDX_W-1:0]   mid_q;
	logic [VALUE_W-1:0] rd_q;
	res_t               res_q;

	logic [31:0]        n32;
	logic [31:0]        n_m1;
	logic [IDX_W:0]     sum;
	logic [IDX_W-1:0]   mid;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W+POS_W-1:0] pos_wide;
	logic [IDX_W+POS_W-1:0] lo_wide;
	logic               pos_ok;
	logic [33:0]        thr;
	logic [33:0]        key34;
	logic               go_right;
	logic [32:0]        diff;
	logic [32:0]        adiff;
	logic               hit;

	assign n32 = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
	                                                      : 32'(entries_in_use);
	assign n_m1     = n32 - 32'd1;
	assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = sum[IDX_W:1];
	assign rd_addr  = ctl.rd_lo ? lo_q : mid;
	assign pos_wide = (IDX_W+POS_W)'(pos_q);
	assign lo_wide  = (IDX_W+POS_W)'(lo_q);
	assign pos_ok   = 32'(pos_q) < 32'(TABLE_DEPTH);

	assign thr      = {3'b000, tolerance} + {{2{rd_q[VALUE_W-1]}}, rd_q};
	assign key34    = {{2{key_q[VALUE_W-1]}}, key_q};
	assign go_right = $signed(thr) < $signed(key34);

	assign diff  = {rd_q[VALUE_W-1], rd_q} - {key_q[VALUE_W-1], key_q};
	assign adiff = diff[32] ? (33'd0 - diff) : diff;
	assign hit   = adiff <= {2'b00, tolerance};

	assign stat.empty     = (n32 == 32'd0);
	assign stat.converged = (lo_q == hi_q);
	assign stat.is_write  = (op_q == OP_WRITE);
	assign res            = res_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && op_q == OP_WRITE && pos_ok) begin
			mem[pos_wide[IDX_W-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_mid || ctl.rd_lo) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= op;
			pos_q <= position;
			key_q <= value;
		end
		if (ctl.init) begin
			lo_q <= '0;
			hi_q <= n_m1[IDX_W-1:0];
		end else if (ctl.upd) begin
			if (go_right) begin
				lo_q <= mid_q + IDX_W'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (ctl.rd_mid) begin
			mid_q <= mid;
		end
		if (ctl.clr) begin
			res_q <= '0;
		end else if (ctl.chk) begin
			res_q.found       <= hit;
			res_q.match_index <= hit ? lo_wide[POS_W-1:0] : '0;
		end
	end

	a_bounds_open: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |-> lo_q < hi_q)
		else $error("bounds update with closed range");

	a_mid_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd_mid && lo_q != hi_q) |-> (mid >= lo_q && mid < hi_q))
		else $error("probe outside the search range");

	a_final_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.chk |-> 32'(lo_q) < n32)
		else $error("final slot beyond entries in use");

endmodule
`default_nettype wire

### design/tolerant_sorted_table_search_top.sv
// Top level: stream ports, configuration registers, output register.
`default_nettype none
// Tolerant search in a sorted table of signed Q16.16 values. A request with
// tuser = 0 writes tdata's value into the given slot; tuser = 1 searches the
// first entries_in_use slots for the first entry whose value plus tolerance is
// not below the key, and reports it when it lies within tolerance of the key.
// One request is handled at a time by a microcoded sequencer over a single
// table memory port: a write goes from dispatch to the result step, a query
// through init, then a probe and a narrow step per halving step (the probe
// reads the memory, the narrow step compares the registered read data), then
// final, check and result; an empty table skips from init to result.
// A request waits in the result step only while the output register is full
// and not drained; a result waiting there does not block the next request.
module tolerant_sorted_table_search_top
	import tsts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF
)(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [IN_DATA_W-1:0]   s_tdata,  // position[9:0], value[41:10], zero pad
	input  wire [0:0]             s_tuser,  // op
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // match_index[9:0], zero pad
	output logic [0:0]            m_tuser,  // found
	input  wire                   cfg_we,
	input  wire [0:0]             cfg_index,
	input  wire [CFG_W-1:0]       cfg_wdata
);

	logic [COUNT_W-1:0] entries_q;
	logic [TOL_W-1:0]   tol_q;
	logic               out_valid_q;
	res_t               out_q;
	ctl_t               ctl;
	dp_stat_t           stat;
	res_t               res;
	logic               req;
	logic               out_busy;

	assign s_tready = ctl.take;
	assign req      = s_tvalid && s_tready;
	assign out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_q.match_index);
	assign m_tuser  = out_q.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			tol_q     <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENTRIES:   entries_q <= cfg_wdata[COUNT_W-1:0];
				REG_TOLERANCE: tol_q     <= cfg_wdata[TOL_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && !out_busy) begin
			out_q <= res;
		end
	end

	tsts_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_busy (out_busy),
		.stat     (stat),
		.ctl      (ctl)
	);

	tsts_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.load           (req),
		.op             (op_t'(s_tuser[0])),
		.position       (s_tdata[POS_W-1:0]),
		.value          (s_tdata[POS_W+VALUE_W-1:POS_W]),
		.entries_in_use (entries_q),
		.tolerance      (tol_q),
		.stat           (stat),
		.res            (res)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req |=> !s_tready)
		else $error("request taken while previous one in flight");

	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && !out_busy) |=> m_tvalid)
		else $error("result lost at output register");

	a_emit_holds_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && out_busy) |=> ctl.emit)
		else $error("result dropped while output stalled");

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for the tolerant sorted table search: directed table plus randomized phases.
`timescale 1ns / 1ps
module tb;
	import tsts_pkg::*;

	localparam int TABLE_N     = 1024;
	localparam int ITEMS_TOTAL = 1400;
	localparam int LIMIT       = 500000;

	typedef struct packed {
		logic             is_cfg;
		reg_idx_t         ridx;
		logic [CFG_W-1:0] rval;
		op_t              op;
		logic [9:0]       pos;
		logic [31:0]      val;
		logic             typed;
		res_t             want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	wire                   s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [0:0]            s_tuser;
	wire                   m_tvalid;
	logic                  m_tready;
	wire  [OUT_DATA_W-1:0] m_tdata;
	wire  [0:0]            m_tuser;
	logic                  cfg_we;
	logic [0:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;

	logic signed [31:0] table_mirror [TABLE_N];
	logic [10:0]        entries_reg;
	logic [30:0]        tol_reg;
	res_t               due_results [$];
	res_t               head;
	stim_row_t          plan [$];
	int unsigned        sent;
	int unsigned        errors;
	int unsigned        cycles;
	int unsigned        tx_gap_pct;
	int unsigned        rx_stall_pct;

	tolerant_sorted_table_search_top #(.TABLE_DEPTH(TABLE_N)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] sat32(input longint x);
		if (x > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'h8000_0000;
		return x[31:0];
	endfunction

	// binary search for the first entry with entry + tol >= key
	function automatic res_t search_mirror(input logic [31:0] key_bits);
		res_t        r;
		int unsigned n, lo, hi, mid;
		longint      key, tol, e, d;
		r   = '0;
		key = longint'($signed(key_bits));
		tol = longint'(tol_reg);
		n   = (entries_reg > TABLE_N) ? TABLE_N : entries_reg;
		if (n == 0)
			return r;
		lo = 0;
		hi = n - 1;
		while (lo != hi) begin
			mid = (lo + hi) / 2;
			if (tol + longint'(table_mirror[mid]) < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		e = longint'(table_mirror[lo]);
		d = (e > key) ? e - key : key - e;
		if (e == key || d <= tol) begin
			r.found       = 1'b1;
			r.match_index = lo[9:0];
		end
		return r;
	endfunction

	function automatic stim_row_t req_row(input op_t op, input logic [9:0] pos,
			input logic [31:0] val, input logic typed = 1'b0, input logic f = 1'b0,
			input logic [9:0] idx = '0);
		stim_row_t r;
		r      = '0;
		r.op   = op;
		r.pos  = pos;
		r.val  = val;
		r.typed = typed;
		r.want.found       = f;
		r.want.match_index = idx;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input reg_idx_t ridx, input logic [CFG_W-1:0] v);
		stim_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.ridx   = ridx;
		r.rval   = v;
		return r;
	endfunction

	function automatic logic [30:0] pick_tol();
		case ($urandom_range(4))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(1 << 16));
			3: return 31'($urandom_range(1 << 22));
			default: return 31'($urandom >> 1);
		endcase
	endfunction

	function automatic logic [31:0] pick_key(input int unsigned n);
		int unsigned sel, span;
		longint      e, t;
		sel = $urandom_range(99);
		if (n == 0 || sel < 15)
			return $urandom;
		if (sel < 20)
			return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		e = longint'(table_mirror[$urandom_range(n - 1)]);
		t = longint'(tol_reg);
		if (sel < 45) begin
			case ($urandom_range(3))
				0: return sat32(e + t);
				1: return sat32(e - t);
				2: return sat32(e + t + 1);
				default: return sat32(e - t - 1);
			endcase
		end
		span = (t + 2 > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(t + 2);
		return sat32(e + longint'($urandom_range(0, 2 * span)) - longint'(span));
	endfunction

	task automatic push_request(input op_t op, input logic [9:0] pos, input logic [31:0] val,
			input logic typed, input res_t want);
		res_t r;
		case ((sent * 3) / ITEMS_TOTAL)
			0: begin
				tx_gap_pct   = 8;
				rx_stall_pct = 67;
			end
			1: begin
				tx_gap_pct   = 67;
				rx_stall_pct = 8;
			end
			default: begin
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end
		endcase
		if (op == OP_WRITE) begin
			table_mirror[pos] = val;
			r = '0;
		end else begin
			r = search_mirror(val);
		end
		due_results.push_back(typed ? want : r);
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, val, pos};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t ridx, input logic [CFG_W-1:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ridx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (ridx == REG_ENTRIES)
			entries_reg = v[10:0];
		else
			tol_reg = v[30:0];
	endtask

	// non-decreasing entries into slots 0..cnt-1
	task automatic load_sorted(input int unsigned cnt);
		longint      v, gap;
		int unsigned i;
		case ($urandom_range(2))
			0: begin
				gap = 3;
				v   = longint'(int'($urandom));
			end
			1: begin
				gap = 1 << 18;
				v   = longint'(int'($urandom));
			end
			default: begin
				gap = 64'sh1_FFFF_FFFE / (cnt + 1);
				v   = -64'sd2147483648;
			end
		endcase
		if (gap > 64'shFFFF_FFFF)
			gap = 64'shFFFF_FFFF;
		for (i = 0; i < cnt; i++) begin
			push_request(OP_WRITE, i[9:0], sat32(v), 1'b0, '0);
			v = v + longint'($urandom_range(0, 32'(gap)));
		end
	endtask

	task automatic run_phase(input logic [10:0] n_cfg, input logic [30:0] tol,
			input int unsigned load_cnt, input int unsigned queries);
		int unsigned n_eff, k;
		write_reg(REG_ENTRIES, {20'b0, n_cfg});
		write_reg(REG_TOLERANCE, tol);
		if (load_cnt != 0)
			load_sorted(load_cnt);
		n_eff = (n_cfg > TABLE_N) ? TABLE_N : n_cfg;
		for (k = 0; k < queries; k++) begin
			if ($urandom_range(49) == 0)
				drain_results();
			if ($urandom_range(9) == 0)
				push_request(OP_WRITE, 10'($urandom_range(1023)), $urandom, 1'b0, '0);
			else
				push_request(OP_QUERY, 10'($urandom_range(1023)), pick_key(n_eff), 1'b0, '0);
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result found=%0d index=%0d",
					$time, m_tuser[0], m_tdata[9:0]);
				errors++;
			end else begin
				head = due_results.pop_front();
				if (m_tuser[0] !== head.found) begin
					$display("%0t: found mismatch, expected %0d actual %0d",
						$time, head.found, m_tuser[0]);
					errors++;
				end
				if (m_tdata[9:0] !== head.match_index) begin
					$display("%0t: match_index mismatch, expected %0d actual %0d",
						$time, head.match_index, m_tdata[9:0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned i, nsel;
		logic [10:0] n;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		entries_reg  = '0;
		tol_reg      = '0;
		sent         = 0;
		errors       = 0;
		cycles       = 0;
		tx_gap_pct   = 8;
		rx_stall_pct = 67;
		for (i = 0; i < TABLE_N; i++)
			table_mirror[i] = '0;

		// empty table after reset, then a four-entry table across the value range
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h0000_0000, 1'b1));
		plan.push_back(req_row(OP_QUERY, 10'd1023, 32'h8000_0000, 1'b1));
		plan.push_back(req_row(OP_WRITE, 10'd0,    32'h8000_0000, 1'b1));
		plan.push_back(req_row(OP_WRITE, 10'd1,    32'hFFFF_0000, 1'b1));
		plan.push_back(req_row(OP_WRITE, 10'd2,    32'h0001_0000, 1'b1));
		plan.push_back(req_row(OP_WRITE, 10'd3,    32'h7FFF_FFFF, 1'b1));
		plan.push_back(req_row(OP_WRITE, 10'd1023, 32'h7FFF_FFFF, 1'b1));
		plan.push_back(cfg_row(REG_ENTRIES, 31'd4));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h8000_0000, 1'b1, 1'b1, 10'd0));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h7FFF_FFFF, 1'b1, 1'b1, 10'd3));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'hFFFF_0000, 1'b1, 1'b1, 10'd1));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h0000_0000, 1'b1));
		plan.push_back(cfg_row(REG_TOLERANCE, 31'h0001_0000));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h0000_0000));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h0001_8000));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h7FFF_0000));
		plan.push_back(cfg_row(REG_TOLERANCE, 31'h7FFF_FFFF));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h8000_0000));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h7FFF_FFFF));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h0000_0000));
		plan.push_back(cfg_row(REG_ENTRIES, 31'd1));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h1234_5678));
		plan.push_back(cfg_row(REG_ENTRIES, 31'd0));
		plan.push_back(req_row(OP_QUERY, 10'd0,    32'h8000_0000, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[j]) begin
			if (plan[j].is_cfg)
				write_reg(plan[j].ridx, plan[j].rval);
			else
				push_request(plan[j].op, plan[j].pos, plan[j].val, plan[j].typed, plan[j].want);
		end

		run_phase(11'd3, pick_tol(), 3, 20);
		run_phase(11'd1024, pick_tol(), 1024, 60);
		run_phase(11'd2047, pick_tol(), 0, 40);
		run_phase(11'(1025 + $urandom_range(1021)), 31'd0, 0, 30);
		while (sent < ITEMS_TOTAL) begin
			nsel = $urandom_range(9);
			n = (nsel == 0) ? 11'd0 : (nsel == 1) ? 11'd1 : 11'($urandom_range(2, 40));
			run_phase(n, pick_tol(), n, $urandom_range(15, 40));
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
